FILE: design/terminal_line_editor_assert.svh
// ---------------------------------------------------------------------------
// Terminal line editor assertion macros
// Shared wrappers for concurrent checks, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// check with explicit clock and active-low reset
`define TLE_ASSERT_CR(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("terminal_line_editor: assertion failed");

// check on the block clock and reset
`define TLE_ASSERT(name, prop) \
  `TLE_ASSERT_CR(name, clk_i, rst_ni, prop)

`endif

FILE: design/tle_pkg.sv
// ---------------------------------------------------------------------------
// Terminal line editor package
// Key, result kind, escape phase and sequencer state types plus byte codes.
// ---------------------------------------------------------------------------
package tle_pkg;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [ADDR_W-3:0] REG_CLEAR = '0;

  localparam logic [7:0] BYTE_CTRLD   = 8'd4;
  localparam logic [7:0] BYTE_TAB     = 8'd9;
  localparam logic [7:0] BYTE_LF      = 8'd10;
  localparam logic [7:0] BYTE_ESC     = 8'd27;
  localparam logic [7:0] BYTE_SPACE   = 8'd32;
  localparam logic [7:0] BYTE_ONE     = 8'd49;
  localparam logic [7:0] BYTE_TWO     = 8'd50;
  localparam logic [7:0] BYTE_THREE   = 8'd51;
  localparam logic [7:0] BYTE_FIVE    = 8'd53;
  localparam logic [7:0] BYTE_SIX     = 8'd54;
  localparam logic [7:0] BYTE_A       = 8'd65;
  localparam logic [7:0] BYTE_B       = 8'd66;
  localparam logic [7:0] BYTE_C       = 8'd67;
  localparam logic [7:0] BYTE_D       = 8'd68;
  localparam logic [7:0] BYTE_F       = 8'd70;
  localparam logic [7:0] BYTE_H       = 8'd72;
  localparam logic [7:0] BYTE_LBRACK  = 8'd91;
  localparam logic [7:0] BYTE_TILDE   = 8'd126;
  localparam logic [7:0] BYTE_DEL     = 8'd127;

  typedef enum logic [3:0] {
    KEY_CTRLD  = 4'd0,
    KEY_DEL    = 4'd1,
    KEY_BKSP   = 4'd2,
    KEY_LEFT   = 4'd3,
    KEY_RIGHT  = 4'd4,
    KEY_UP     = 4'd5,
    KEY_DOWN   = 4'd6,
    KEY_END    = 4'd7,
    KEY_HOME   = 4'd8,
    KEY_RETURN = 4'd9,
    KEY_TAB    = 4'd10,
    KEY_CHAR   = 4'd11,
    KEY_NONE   = 4'd15
  } key_e;

  typedef enum logic [1:0] {
    KIND_EDIT  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_EXIT  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_FIRST,
    ESC_SECOND,
    ESC_SKIP,
    ESC_TWO_MORE,
    ESC_ONE_MORE_LONG,
    ESC_ONE_MORE
  } esc_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OUT,
    ST_INS,
    ST_INS_PUT,
    ST_DEL,
    ST_RET
  } state_e;

endpackage

FILE: design/terminal_line_editor.sv
// ---------------------------------------------------------------------------
// Terminal line editor
// Decodes terminal bytes and escape sequences and edits a line held in a
// one-read, one-write line memory; return streams the line out.
// ---------------------------------------------------------------------------
// One byte is taken at a time; in_stall_o stays high while it is worked on.
// A byte that only advances escape decoding leaves the editor idle and gives
// no result. A key that just moves the cursor or does nothing passes through
// ST_OUT to the result register. Insert walks the line memory from the end
// down to the cursor, one entry per cycle; delete and backspace walk from the
// cursor up. Return streams the line's characters at one per cycle while the
// result side does not stall, after a registered memory read. The result
// register frees the input side while a result waits. No memory clear runs
// after reset.
module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [3:0]                 key_code_o,
  output logic [CHAR_W-1:0]          out_char_o,
  output logic [POS_W-1:0]           cursor_pos_o,
  output logic [POS_W-1:0]           line_length_o,
  output logic                       full_refused_o,
  output logic                       last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned CW = $clog2(LINE_DEPTH + 1);

  state_e              state_q, state_d;
  esc_e                esc_q, esc_d;
  logic                esc_del_q, esc_del_d;
  logic [CW-1:0]       cursor_q, cursor_d;
  logic [CW-1:0]       length_q, length_d;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_addr_q, pend_addr_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  kind_e               res_kind_q, res_kind_d;
  key_e                res_key_q, res_key_d;
  logic                res_ref_q, res_ref_d;
  logic                cfg_clear_q;

  logic [CHAR_W-1:0]   line_mem [LINE_DEPTH];
  logic [CHAR_W-1:0]   rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CHAR_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;

  logic                out_valid_q;
  kind_e               out_kind_q, out_kind_d;
  key_e                out_key_q, out_key_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic [CW-1:0]       out_cur_q, out_len_q;
  logic                out_ref_q, out_ref_d;
  logic                out_last_q, out_last_d;
  logic                out_load;
  logic                out_free;

  logic                in_take;
  logic                cfg_we;
  key_e                dec_key;
  esc_e                dec_esc;
  logic                dec_esc_del;
  logic [CW-1:0]       ptr_inc, ptr_dec;
  logic [CW-1:0]       cur_inc, cur_dec;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ptr_inc    = ptr_q + 1'b1;
  assign ptr_dec    = ptr_q - 1'b1;
  assign cur_inc    = cursor_q + 1'b1;
  assign cur_dec    = cursor_q - 1'b1;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_CLEAR);
  assign prdata = (paddr[ADDR_W-1:2] == REG_CLEAR) ? DATA_W'(cfg_clear_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_clear_q <= 1'b1;
    end else if (cfg_we) begin
      cfg_clear_q <= pwdata[0];
    end
  end

  // byte decoder
  always_comb begin
    dec_key     = KEY_NONE;
    dec_esc     = ESC_IDLE;
    dec_esc_del = esc_del_q;
    case (esc_q)
      ESC_FIRST: begin
        dec_esc = (in_byte_i == BYTE_LBRACK) ? ESC_SECOND : ESC_SKIP;
      end
      ESC_SKIP: begin
        dec_esc = ESC_IDLE;
      end
      ESC_SECOND: begin
        if (in_byte_i == BYTE_A) begin
          dec_key = KEY_UP;
        end else if (in_byte_i == BYTE_B) begin
          dec_key = KEY_DOWN;
        end else if (in_byte_i == BYTE_D) begin
          dec_key = KEY_LEFT;
        end else if (in_byte_i == BYTE_C) begin
          dec_key = KEY_RIGHT;
        end else if (in_byte_i == BYTE_F) begin
          dec_key = KEY_END;
        end else if (in_byte_i == BYTE_H) begin
          dec_key = KEY_HOME;
        end else if (in_byte_i == BYTE_ONE) begin
          dec_esc = ESC_TWO_MORE;
        end else if (in_byte_i == BYTE_TWO || in_byte_i == BYTE_THREE ||
                     in_byte_i == BYTE_FIVE || in_byte_i == BYTE_SIX) begin
          dec_esc     = ESC_ONE_MORE;
          dec_esc_del = (in_byte_i == BYTE_THREE);
        end
      end
      ESC_TWO_MORE: begin
        dec_esc = ESC_ONE_MORE_LONG;
      end
      ESC_ONE_MORE_LONG: begin
        dec_esc = ESC_IDLE;
      end
      ESC_ONE_MORE: begin
        if (esc_del_q && in_byte_i == BYTE_TILDE) begin
          dec_key = KEY_DEL;
        end
      end
      default: begin
        if (in_byte_i == BYTE_CTRLD) begin
          dec_key = KEY_CTRLD;
        end else if (in_byte_i == BYTE_ESC) begin
          dec_esc = ESC_FIRST;
        end else if (in_byte_i == BYTE_DEL) begin
          dec_key = KEY_BKSP;
        end else if (in_byte_i == BYTE_LF) begin
          dec_key = KEY_RETURN;
        end else if (in_byte_i == BYTE_TAB) begin
          dec_key = KEY_TAB;
        end else if (in_byte_i >= BYTE_SPACE && in_byte_i <= BYTE_TILDE) begin
          dec_key = KEY_CHAR;
        end
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    esc_d       = esc_q;
    esc_del_d   = esc_del_q;
    cursor_d    = cursor_q;
    length_d    = length_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    char_d      = char_q;
    res_kind_d  = res_kind_q;
    res_key_d   = res_key_q;
    res_ref_d   = res_ref_q;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = rdata_q;
    mem_raddr   = '0;
    out_load    = 1'b0;
    out_kind_d  = res_kind_q;
    out_key_d   = res_key_q;
    out_char_d  = '0;
    out_ref_d   = res_ref_q;
    out_last_d  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          esc_d      = dec_esc;
          esc_del_d  = dec_esc_del;
          res_key_d  = dec_key;
          res_kind_d = KIND_EDIT;
          res_ref_d  = 1'b0;
          pend_d     = 1'b0;
          state_d    = ST_OUT;
          case (dec_key)
            KEY_NONE: begin
              state_d = ST_IDLE;
            end
            KEY_CTRLD: begin
              res_kind_d = KIND_EXIT;
            end
            KEY_LEFT: begin
              if (cursor_q != '0) begin
                cursor_d = cur_dec;
              end
            end
            KEY_RIGHT: begin
              if (cursor_q < length_q) begin
                cursor_d = cur_inc;
              end
            end
            KEY_HOME: begin
              cursor_d = '0;
            end
            KEY_END: begin
              cursor_d = length_q;
            end
            KEY_DEL: begin
              if (cursor_q < length_q) begin
                ptr_d   = cur_inc;
                state_d = ST_DEL;
              end
            end
            KEY_BKSP: begin
              if (cursor_q != '0) begin
                cursor_d = cur_dec;
                ptr_d    = cursor_q;
                state_d  = ST_DEL;
              end
            end
            KEY_CHAR: begin
              if (length_q >= CW'(LINE_DEPTH)) begin
                res_ref_d = 1'b1;
              end else begin
                char_d  = in_byte_i[CHAR_W-1:0];
                ptr_d   = length_q;
                state_d = ST_INS;
              end
            end
            KEY_RETURN: begin
              if (cfg_clear_q) begin
                cursor_d = '0;
                length_d = '0;
              end else begin
                cursor_d = length_q;
              end
              if (length_q == '0) begin
                res_kind_d = KIND_EMPTY;
              end else begin
                cnt_d   = length_q;
                ptr_d   = '0;
                state_d = ST_RET;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_INS: begin
        mem_we = pend_q;
        if (ptr_q > cursor_q) begin
          mem_raddr   = ptr_dec[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[AW-1:0];
          ptr_d       = ptr_dec;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_INS_PUT;
        end
      end

      ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_q[AW-1:0];
        mem_wdata = char_q;
        length_d  = length_q + 1'b1;
        cursor_d  = cur_inc;
        state_d   = ST_OUT;
      end

      ST_DEL: begin
        mem_we = pend_q;
        if (ptr_q < length_q) begin
          mem_raddr   = ptr_q[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = ptr_dec[AW-1:0];
          ptr_d       = ptr_inc;
        end else begin
          pend_d   = 1'b0;
          length_d = length_q - 1'b1;
          state_d  = ST_OUT;
        end
      end

      ST_RET: begin
        mem_raddr = ptr_q[AW-1:0];
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_CHAR;
          out_char_d = rdata_q;
          out_last_d = (ptr_inc == cnt_q);
          if (ptr_inc == cnt_q) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d     = ptr_inc;
            mem_raddr = ptr_inc[AW-1:0];
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      esc_q     <= ESC_IDLE;
      esc_del_q <= 1'b0;
      cursor_q  <= '0;
      length_q  <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      esc_q     <= esc_d;
      esc_del_q <= esc_del_d;
      cursor_q  <= cursor_d;
      length_q  <= length_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    char_q      <= char_d;
    res_kind_q  <= res_kind_d;
    res_key_q   <= res_key_d;
    res_ref_q   <= res_ref_d;
  end

  // line memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= line_mem[mem_raddr];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_key_q  <= out_key_d;
      out_char_q <= out_char_d;
      out_cur_q  <= cursor_q;
      out_len_q  <= length_q;
      out_ref_q  <= out_ref_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign key_code_o     = out_key_q;
  assign out_char_o     = out_char_q;
  assign cursor_pos_o   = POS_W'(out_cur_q);
  assign line_length_o  = POS_W'(out_len_q);
  assign full_refused_o = out_ref_q;
  assign last_o         = out_last_q;

  `include "terminal_line_editor_assert.svh"

  `TLE_ASSERT(a_cursor_in_line, cursor_q <= length_q)
  `TLE_ASSERT(a_length_bound, length_q <= CW'(LINE_DEPTH))
  `TLE_ASSERT(a_no_write_idle, (state_q == ST_IDLE) |-> !mem_we)
  `TLE_ASSERT(a_pend_in_walk, pend_q |-> (state_q == ST_INS || state_q == ST_DEL))
  `TLE_ASSERT(a_ret_ptr_bound, (state_q == ST_RET) |-> (ptr_q < cnt_q))

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Terminal line editor testbench
// Feeds terminal bytes through the valid/stall input and checks every result
// beat against a line-editing predictor kept in the testbench. The run starts
// with a table of keys, then moves to random key streams under both return
// modes, with long fill bursts, random idling on both sides and a long stall
// of the result side.
// ----------------------------------------------------------------------------
module testbench;
  import tle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = 64;

  typedef struct packed {
    kind_e             kind;
    key_e              key;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  cur;
    logic [POS_W-1:0]  len;
    logic              refused;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    beat_t      want;
  } row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [7:0]        in_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        kind_o;
  logic [3:0]        key_code_o;
  logic [CHAR_W-1:0] out_char_o;
  logic [POS_W-1:0]  cursor_pos_o;
  logic [POS_W-1:0]  line_length_o;
  logic              full_refused_o;
  logic              last_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  terminal_line_editor #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_byte_i,
    .out_valid_o, .out_stall_i, .kind_o, .key_code_o, .out_char_o,
    .cursor_pos_o, .line_length_o, .full_refused_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [CHAR_W-1:0] line_chars [LINE_DEPTH];
  int                cur_pos     = 0;
  int                line_len    = 0;
  esc_e              esc_phase   = ESC_IDLE;
  logic [7:0]        esc_lead    = '0;
  bit                send_clears = 1'b1;

  beat_t expected_beats [$];
  int    mismatches  = 0;
  int    bytes_taken = 0;
  int    rx_gap      = 0;
  bit    rx_hold     = 1'b0;
  bit    hold_req    = 1'b0;
  bit    calm        = 1'b0;
  row_t  opening [30];

  logic [7:0] arrow_finals [6] = '{BYTE_A, BYTE_B, BYTE_C, BYTE_D, BYTE_F, BYTE_H};
  logic [7:0] short_leads  [4] = '{BYTE_TWO, BYTE_THREE, BYTE_FIVE, BYTE_SIX};

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 200)
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  function automatic key_e decode_byte(input logic [7:0] b, output logic [CHAR_W-1:0] ch);
    esc_e was;
    was = esc_phase;
    ch = '0;
    esc_phase = ESC_IDLE;
    case (was)
      ESC_FIRST: begin
        esc_phase = (b == BYTE_LBRACK) ? ESC_SECOND : ESC_SKIP;
        return KEY_NONE;
      end
      ESC_SKIP, ESC_ONE_MORE_LONG: return KEY_NONE;
      ESC_SECOND: begin
        case (b)
          BYTE_A: return KEY_UP;
          BYTE_B: return KEY_DOWN;
          BYTE_C: return KEY_RIGHT;
          BYTE_D: return KEY_LEFT;
          BYTE_F: return KEY_END;
          BYTE_H: return KEY_HOME;
          BYTE_ONE: esc_phase = ESC_TWO_MORE;
          BYTE_TWO, BYTE_THREE, BYTE_FIVE, BYTE_SIX: begin
            esc_lead = b;
            esc_phase = ESC_ONE_MORE;
          end
          default: ;
        endcase
        return KEY_NONE;
      end
      ESC_TWO_MORE: begin
        esc_phase = ESC_ONE_MORE_LONG;
        return KEY_NONE;
      end
      ESC_ONE_MORE: return (esc_lead == BYTE_THREE && b == BYTE_TILDE) ? KEY_DEL : KEY_NONE;
      default: ;
    endcase
    if (b == BYTE_CTRLD) return KEY_CTRLD;
    if (b == BYTE_ESC) begin
      esc_phase = ESC_FIRST;
      return KEY_NONE;
    end
    if (b == BYTE_DEL) return KEY_BKSP;
    if (b == BYTE_LF) return KEY_RETURN;
    if (b == BYTE_TAB) return KEY_TAB;
    if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
      ch = b[CHAR_W-1:0];
      return KEY_CHAR;
    end
    return KEY_NONE;
  endfunction

  function automatic void erase_char(input int pos);
    int i;
    if (pos >= line_len) return;
    for (i = pos; i + 1 < line_len; i++) line_chars[i] = line_chars[i + 1];
    line_len--;
  endfunction

  task automatic edit_line(input logic [7:0] b);
    key_e              key;
    logic [CHAR_W-1:0] ch;
    beat_t             r;
    int                i;
    int                n;
    key = decode_byte(b, ch);
    r = '0;
    r.kind = KIND_EDIT;
    r.key = key;
    r.last = 1'b1;
    case (key)
      KEY_NONE: return;
      KEY_CTRLD: r.kind = KIND_EXIT;
      KEY_LEFT: if (cur_pos > 0) cur_pos--;
      KEY_RIGHT: if (cur_pos < line_len) cur_pos++;
      KEY_HOME: cur_pos = 0;
      KEY_END: cur_pos = line_len;
      KEY_DEL: erase_char(cur_pos);
      KEY_BKSP: if (cur_pos > 0) begin
        cur_pos--;
        erase_char(cur_pos);
      end
      KEY_CHAR: if (line_len >= LINE_DEPTH) begin
        r.refused = 1'b1;
      end else begin
        for (i = line_len; i > cur_pos; i--) line_chars[i] = line_chars[i - 1];
        line_chars[cur_pos] = ch;
        line_len++;
        cur_pos++;
      end
      KEY_RETURN: begin
        n = line_len;
        if (send_clears) begin
          line_len = 0;
          cur_pos = 0;
        end else begin
          cur_pos = line_len;
        end
        r.cur = POS_W'(cur_pos);
        r.len = POS_W'(line_len);
        if (n == 0) begin
          r.kind = KIND_EMPTY;
        end else begin
          r.kind = KIND_CHAR;
          for (i = 0; i < n; i++) begin
            r.ch = line_chars[i];
            r.last = (i == n - 1);
            expected_beats.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.cur = POS_W'(cur_pos);
    r.len = POS_W'(line_len);
    expected_beats.push_back(r);
  endtask

  function automatic row_t plain(input logic [7:0] b);
    row_t r;
    r = '0;
    r.b = b;
    return r;
  endfunction

  function automatic row_t typed(input logic [7:0] b, input kind_e kind, input key_e key);
    row_t r;
    r = '0;
    r.b = b;
    r.typed = 1'b1;
    r.want.kind = kind;
    r.want.key = key;
    r.want.last = 1'b1;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic use_typed, input beat_t want);
    int gap;
    int n0;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n0 = expected_beats.size();
    edit_line(b);
    if (use_typed) begin
      while (expected_beats.size() > n0) void'(expected_beats.pop_back());
      expected_beats.push_back(want);
    end
    bytes_taken++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic esc_key(input logic [7:0] final_b);
    put_byte(BYTE_ESC);
    put_byte(BYTE_LBRACK);
    put_byte(final_b);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_clear_on_return(input bit v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_CLEAR, 2'b00};
    pwdata <= DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    send_clears = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[0] !== v) report_mismatch("clear_on_return readback", prdata, 32'(v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_token();
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    if (r < 40) put_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
    else if (r < 62) esc_key(arrow_finals[$urandom_range(0, 5)]);
    else if (r < 70) begin
      esc_key(BYTE_THREE);
      put_byte(BYTE_TILDE);
    end
    else if (r < 76) put_byte(BYTE_DEL);
    else if (r < 79) put_byte(BYTE_TAB);
    else if (r < 81) put_byte(BYTE_CTRLD);
    else if (r < 86) put_byte(BYTE_LF);
    else if (r < 90) begin
      put_byte(BYTE_ESC);
      put_byte(8'($urandom_range(0, 255)));
      put_byte(8'($urandom_range(0, 255)));
    end
    else if (r < 93) begin
      esc_key(BYTE_ONE);
      put_byte(8'($urandom_range(0, 255)));
      put_byte(8'($urandom_range(0, 255)));
    end
    else if (r < 97) begin
      esc_key(short_leads[$urandom_range(0, 3)]);
      put_byte($urandom_range(0, 1) ? BYTE_TILDE : 8'($urandom_range(0, 255)));
    end
    else if (r < 98) esc_key(8'($urandom_range(0, 255)));
    else put_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 49) == 0) drain_results();
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = bytes_taken + count;
    while (bytes_taken < stop_at) send_token();
  endtask

  // types 68 keys, mostly characters, to fill the line, with some edits near the front
  task automatic fill_line();
    int k;
    for (k = 0; k < 68; k++) begin
      case ($urandom_range(0, 19))
        0: esc_key(BYTE_H);
        1: esc_key(BYTE_D);
        default: put_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
      endcase
    end
  endtask

  // result side: random stall per beat, plus the long hold-off
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i) rx_gap = calm ? 0 : $urandom_range(0, 11);
    else if (rx_gap > 0) rx_gap = rx_gap - 1;
    out_stall_i <= rx_hold || (rx_gap > 0);
  end

  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (500) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : check_beats
    beat_t e;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with nothing expected, key_code", 32'(key_code_o), 0);
      end else begin
        e = expected_beats.pop_front();
        if (kind_o !== e.kind) report_mismatch("kind", 32'(kind_o), 32'(e.kind));
        if (key_code_o !== e.key) report_mismatch("key_code", 32'(key_code_o), 32'(e.key));
        if (out_char_o !== e.ch) report_mismatch("out_char", 32'(out_char_o), 32'(e.ch));
        if (cursor_pos_o !== e.cur)
          report_mismatch("cursor_pos", 32'(cursor_pos_o), 32'(e.cur));
        if (line_length_o !== e.len)
          report_mismatch("line_length", 32'(line_length_o), 32'(e.len));
        if (full_refused_o !== e.refused)
          report_mismatch("full_refused", 32'(full_refused_o), 32'(e.refused));
        if (last_o !== e.last) report_mismatch("last", 32'(last_o), 32'(e.last));
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL terminal_line_editor");
    $finish;
  end

  initial begin
    opening = '{
      typed(BYTE_LF, KIND_EMPTY, KEY_RETURN),
      typed(BYTE_CTRLD, KIND_EXIT, KEY_CTRLD),
      typed(BYTE_DEL, KIND_EDIT, KEY_BKSP),
      plain(BYTE_ESC), plain(BYTE_LBRACK), plain(BYTE_THREE),
      typed(BYTE_TILDE, KIND_EDIT, KEY_DEL),
      plain(BYTE_SPACE), plain(BYTE_TILDE),
      plain(BYTE_ESC), plain(BYTE_LBRACK), plain(BYTE_D),
      plain(BYTE_ESC), plain(BYTE_LBRACK), plain(BYTE_H),
      plain(BYTE_ESC), plain(BYTE_LBRACK), plain(BYTE_F),
      plain(BYTE_ESC), plain(BYTE_LBRACK), plain(BYTE_A),
      plain(BYTE_ESC), plain(BYTE_LBRACK), plain(BYTE_B),
      plain(BYTE_ESC), plain(BYTE_LBRACK), plain(BYTE_C),
      plain(BYTE_TAB), plain(BYTE_DEL), plain(BYTE_LF)
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i].b, opening[i].typed, opening[i].want);
    drain_results();

    // line kept after return; result side held off early in this phase
    set_clear_on_return(1'b0);
    hold_req = 1'b1;
    run_random(90);
    drain_results();

    set_clear_on_return(1'b1);
    fill_line();
    put_byte(BYTE_LF);
    run_random(50);
    drain_results();

    set_clear_on_return(1'b0);
    fill_line();
    put_byte(BYTE_LF);
    put_byte(BYTE_SPACE);
    put_byte(BYTE_TILDE);
    put_byte(BYTE_LF);
    run_random(30);
    drain_results();

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS terminal_line_editor");
    end else begin
      $display("FAIL terminal_line_editor");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/tle_pkg.sv
design/terminal_line_editor.sv
verif/testbench.sv
